>>> design/dtsc_pkg.sv
package dtsc_pkg;

    // Field widths
    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 12;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int SecW   = 6;
    localparam int StepW  = 3;

    // Commands carried by an input word
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_PLUS  = 2'd1,
        CMD_MINUS = 2'd2,
        CMD_SET   = 2'd3
    } t_cmd;

    // Edit step, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DAY    = 7'b0000010,
        ST_MONTH  = 7'b0000100,
        ST_YEAR   = 7'b0001000,
        ST_HOUR   = 7'b0010000,
        ST_MINUTE = 7'b0100000,
        ST_SECOND = 7'b1000000
    } t_step;

    // Step codes as shown on the result word
    localparam logic [StepW-1:0] CODE_IDLE   = 3'd0;
    localparam logic [StepW-1:0] CODE_DAY    = 3'd1;
    localparam logic [StepW-1:0] CODE_MONTH  = 3'd2;
    localparam logic [StepW-1:0] CODE_YEAR   = 3'd3;
    localparam logic [StepW-1:0] CODE_HOUR   = 3'd4;
    localparam logic [StepW-1:0] CODE_MINUTE = 3'd5;
    localparam logic [StepW-1:0] CODE_SECOND = 3'd6;

    // Register indexes on the config port (paddr[2])
    localparam logic REG_YEAR_FLOOR = 1'b0;
    localparam logic REG_YEAR_CEIL  = 1'b1;

    typedef struct packed {
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   second;
    } t_dt;

    localparam t_dt DtReset = '{
        day:    5'd1,
        month:  4'd5,
        year:   12'd2025,
        hour:   5'd0,
        minute: 6'd0,
        second: 6'd0
    };

    localparam logic [YearW-1:0] YearFloorReset = 12'd2020;
    localparam logic [YearW-1:0] YearCeilReset  = 12'd2050;

    // 2^17 / 25 rounded up; y*Recip25 has low 17 bits below Recip25 iff 25 divides y
    localparam logic [16:0] Recip25 = 17'd5243;

    function automatic logic [StepW-1:0] step_code(input t_step s);
        logic [StepW-1:0] c;
        case (s)
            ST_DAY:    c = CODE_DAY;
            ST_MONTH:  c = CODE_MONTH;
            ST_YEAR:   c = CODE_YEAR;
            ST_HOUR:   c = CODE_HOUR;
            ST_MINUTE: c = CODE_MINUTE;
            ST_SECOND: c = CODE_SECOND;
            default:   c = CODE_IDLE;
        endcase
        return c;
    endfunction

    // Gregorian leap rule: by 4, not by 100 unless by 400 (400 = 16 * 25)
    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [28:0] prod;
        logic        div25;
        logic        div4;
        logic        div16;
        prod  = {17'd0, y} * {12'd0, Recip25};
        div25 = (prod[16:0] < Recip25);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic [YearW-1:0]  y);
        logic [DayW-1:0] len;
        case (m)
            4'd2:                     len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> design/dtsc_update.sv
module dtsc_update (
    input  dtsc_pkg::t_cmd              i_cmd,
    input  dtsc_pkg::t_step             i_step,
    input  dtsc_pkg::t_dt               i_dt,
    input  dtsc_pkg::t_dt               i_load,
    input  logic [dtsc_pkg::YearW-1:0]  i_year_floor,
    input  logic [dtsc_pkg::YearW-1:0]  i_year_ceil,
    output dtsc_pkg::t_step             o_step,
    output dtsc_pkg::t_dt               o_dt,
    output logic                        o_commit
);

    logic                        up;
    logic [dtsc_pkg::DayW-1:0]   day_adj;
    logic [dtsc_pkg::MonthW-1:0] month_adj;
    logic [dtsc_pkg::YearW-1:0]  year_adj;
    logic [dtsc_pkg::DayW-1:0]   lim;
    logic [5:0]                  hr_t;
    logic [6:0]                  min_t;
    logic [6:0]                  sec_t;
    logic [dtsc_pkg::HourW-1:0]  hour_adj;
    logic [dtsc_pkg::MinW-1:0]   minute_adj;
    logic [dtsc_pkg::SecW-1:0]   second_adj;

    // Per-field plus/minus with wrap
    always_comb begin
        up = (i_cmd == dtsc_pkg::CMD_PLUS);

        // day wraps at 31 whatever the month
        if (up) begin
            day_adj = (i_dt.day >= 5'd31) ? 5'd1 : i_dt.day + 5'd1;
        end else begin
            day_adj = (i_dt.day <= 5'd1) ? 5'd31 : i_dt.day - 5'd1;
        end

        if (up) begin
            month_adj = (i_dt.month >= 4'd12) ? i_dt.month - 4'd11 : i_dt.month + 4'd1;
        end else begin
            month_adj = (i_dt.month <= 4'd1) ? 4'd12 : i_dt.month - 4'd1;
        end

        // year window: plus wraps from ceiling to floor, minus from floor to ceiling
        if (up) begin
            year_adj = (i_dt.year < i_year_ceil) ? i_dt.year + 12'd1 : i_year_floor;
        end else begin
            year_adj = (i_dt.year > i_year_floor) ? i_dt.year - 12'd1 : i_year_ceil;
        end

        // hour mod 24; minus adds 23, which may need two subtractions
        hr_t = {1'b0, i_dt.hour} + (up ? 6'd1 : 6'd23);
        if (hr_t >= 6'd48) begin
            hr_t = hr_t - 6'd48;
        end else if (hr_t >= 6'd24) begin
            hr_t = hr_t - 6'd24;
        end
        hour_adj = hr_t[4:0];

        // minute and second mod 60
        min_t = {1'b0, i_dt.minute} + (up ? 7'd1 : 7'd59);
        if (min_t >= 7'd120) begin
            min_t = min_t - 7'd120;
        end else if (min_t >= 7'd60) begin
            min_t = min_t - 7'd60;
        end
        minute_adj = min_t[5:0];

        sec_t = {1'b0, i_dt.second} + (up ? 7'd1 : 7'd59);
        if (sec_t >= 7'd120) begin
            sec_t = sec_t - 7'd120;
        end else if (sec_t >= 7'd60) begin
            sec_t = sec_t - 7'd60;
        end
        second_adj = sec_t[5:0];
    end

    // Command decode and day clamp
    always_comb begin
        o_step   = i_step;
        o_dt     = i_dt;
        o_commit = 1'b0;
        lim      = dtsc_pkg::month_len(month_adj, i_dt.year);
        case (i_cmd)
            dtsc_pkg::CMD_START: begin
                o_dt   = i_load;
                o_step = dtsc_pkg::ST_DAY;
            end
            dtsc_pkg::CMD_PLUS, dtsc_pkg::CMD_MINUS: begin
                case (i_step)
                    dtsc_pkg::ST_DAY: begin
                        o_dt.day = day_adj;
                    end
                    dtsc_pkg::ST_MONTH: begin
                        lim        = dtsc_pkg::month_len(month_adj, i_dt.year);
                        o_dt.month = month_adj;
                        o_dt.day   = (i_dt.day > lim) ? lim : i_dt.day;
                    end
                    dtsc_pkg::ST_YEAR: begin
                        lim       = dtsc_pkg::month_len(i_dt.month, year_adj);
                        o_dt.year = year_adj;
                        if (i_dt.month == 4'd2 && i_dt.day > lim) begin
                            o_dt.day = lim;
                        end
                    end
                    dtsc_pkg::ST_HOUR:   o_dt.hour   = hour_adj;
                    dtsc_pkg::ST_MINUTE: o_dt.minute = minute_adj;
                    dtsc_pkg::ST_SECOND: o_dt.second = second_adj;
                    default: ;
                endcase
            end
            dtsc_pkg::CMD_SET: begin
                case (i_step)
                    dtsc_pkg::ST_DAY:    o_step = dtsc_pkg::ST_MONTH;
                    dtsc_pkg::ST_MONTH:  o_step = dtsc_pkg::ST_YEAR;
                    dtsc_pkg::ST_YEAR:   o_step = dtsc_pkg::ST_HOUR;
                    dtsc_pkg::ST_HOUR:   o_step = dtsc_pkg::ST_MINUTE;
                    dtsc_pkg::ST_MINUTE: o_step = dtsc_pkg::ST_SECOND;
                    dtsc_pkg::ST_SECOND: begin
                        o_step   = dtsc_pkg::ST_IDLE;
                        o_commit = 1'b1;
                    end
                    default:             o_step = dtsc_pkg::ST_IDLE;
                endcase
            end
            default: ;
        endcase
    end

endmodule

>>> design/date_time_setting_controller.sv
// Accepted words go from the input register to the output register, one word per cycle
//   while the output is not stalled; the input register frees each cycle the output register
//   moves, and the edit state is read and written in the same cycle as the update logic.
// Reset (i_rst_n low, synchronous): both stages empty, step idle, date 1.5.2025 00:00:00,
//   year window 2020..2050.
module date_time_setting_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_cmd,
    input  logic [dtsc_pkg::DayW-1:0]    i_load_day,
    input  logic [dtsc_pkg::MonthW-1:0]  i_load_month,
    input  logic [dtsc_pkg::YearW-1:0]   i_load_year,
    input  logic [dtsc_pkg::HourW-1:0]   i_load_hour,
    input  logic [dtsc_pkg::MinW-1:0]    i_load_minute,
    input  logic [dtsc_pkg::SecW-1:0]    i_load_second,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dtsc_pkg::StepW-1:0]   o_step,
    output logic [dtsc_pkg::DayW-1:0]    o_cur_day,
    output logic [dtsc_pkg::MonthW-1:0]  o_cur_month,
    output logic [dtsc_pkg::YearW-1:0]   o_cur_year,
    output logic [dtsc_pkg::HourW-1:0]   o_cur_hour,
    output logic [dtsc_pkg::MinW-1:0]    o_cur_minute,
    output logic [dtsc_pkg::SecW-1:0]    o_cur_second,
    output logic                         o_commit,
    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic                        r_in_valid;
    dtsc_pkg::t_cmd              r_in_cmd;
    dtsc_pkg::t_dt               r_in_load;
    dtsc_pkg::t_step             r_step;
    dtsc_pkg::t_dt               r_dt;
    logic [dtsc_pkg::YearW-1:0]  r_year_floor;
    logic [dtsc_pkg::YearW-1:0]  r_year_ceil;
    logic                        r_out_valid;
    logic [dtsc_pkg::StepW-1:0]  r_out_step;
    dtsc_pkg::t_dt               r_out_dt;
    logic                        r_out_commit;

    dtsc_pkg::t_step             n_step;
    dtsc_pkg::t_dt               n_dt;
    logic                        n_commit;
    logic                        out_free;
    logic                        process;
    logic                        cfg_wr;

    // Handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign process    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || process;

    // Config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == dtsc_pkg::REG_YEAR_CEIL) ? {20'd0, r_year_ceil}
                                                         : {20'd0, r_year_floor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_floor <= dtsc_pkg::YearFloorReset;
            r_year_ceil  <= dtsc_pkg::YearCeilReset;
        end else if (cfg_wr) begin
            if (paddr[2] == dtsc_pkg::REG_YEAR_CEIL) begin
                r_year_ceil <= pwdata[11:0];
            end else begin
                r_year_floor <= pwdata[11:0];
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd  <= dtsc_pkg::t_cmd'(i_cmd);
            r_in_load <= '{day: i_load_day, month: i_load_month, year: i_load_year,
                           hour: i_load_hour, minute: i_load_minute,
                           second: i_load_second};
        end
    end

    // Update logic
    dtsc_update u_update (
        .i_cmd        (r_in_cmd),
        .i_step       (r_step),
        .i_dt         (r_dt),
        .i_load       (r_in_load),
        .i_year_floor (r_year_floor),
        .i_year_ceil  (r_year_ceil),
        .o_step       (n_step),
        .o_dt         (n_dt),
        .o_commit     (n_commit)
    );

    // Edit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dtsc_pkg::ST_IDLE;
            r_dt   <= dtsc_pkg::DtReset;
        end else if (process) begin
            r_step <= n_step;
            r_dt   <= n_dt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_step   <= dtsc_pkg::step_code(n_step);
            r_out_dt     <= n_dt;
            r_out_commit <= n_commit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_step       = r_out_step;
    assign o_cur_day    = r_out_dt.day;
    assign o_cur_month  = r_out_dt.month;
    assign o_cur_year   = r_out_dt.year;
    assign o_cur_hour   = r_out_dt.hour;
    assign o_cur_minute = r_out_dt.minute;
    assign o_cur_second = r_out_dt.second;
    assign o_commit     = r_out_commit;

`ifndef SYNTHESIS
    // commit only ever goes out with the step back at idle
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_commit |-> r_out_step == dtsc_pkg::CODE_IDLE)
        else $error("commit without idle step");

    // a stalled word in the input register is kept
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid)
        else $error("input word lost under stall");

    // start always lands in the day step
    a_start_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in_cmd == dtsc_pkg::CMD_START |=> r_step == dtsc_pkg::ST_DAY)
        else $error("start did not enter day step");

    // a processed word always fills the output register
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |=> r_out_valid)
        else $error("result word dropped");
`endif

endmodule
